// ===== design/ipd_pkg.sv =====
// Package for the IMU packet deframer: capture store sizing, frame kinds,
// packet type codes, receive phases and the result record.
// No dependencies; every other design file imports it.
`default_nettype none

package ipd_pkg;

  // Body bytes kept for decoding; bytes beyond this are counted only.
  // The decoder reads body offsets up to 15, so this must be at least 16.
  localparam int unsigned CAPTURE_BYTES = 16;
  localparam int unsigned CAP_IDX_W     = $clog2(CAPTURE_BYTES);
  localparam logic [15:0] CAP_LIMIT     = 16'(CAPTURE_BYTES);

  typedef logic [CAPTURE_BYTES-1:0][7:0] cap_view_t;

  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_ANGLE_Q87   = 3'd0,
    KIND_ANGLE_FLOAT = 3'd1,
    KIND_TEST_INT    = 3'd2,
    KIND_TEST_FLOAT  = 3'd3,
    KIND_UNKNOWN     = 3'd4
  } frame_kind_t;

  localparam logic [15:0] TYPE_ANGLE_Q87   = 16'd1;
  localparam logic [15:0] TYPE_ANGLE_FLOAT = 16'd2;
  localparam logic [15:0] TYPE_TEST_INT    = 16'd11;
  localparam logic [15:0] TYPE_TEST_FLOAT  = 16'd12;
  localparam logic [31:0] TEST_UNKNOWN     = 32'h0000_00AA;

  typedef struct packed {
    frame_kind_t kind;
    logic [15:0] packet_type;
    logic [15:0] payload_length;
    logic [31:0] roll;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic [31:0] test_value;
    logic [7:0]  checksum;
  } result_t;

endpackage

`default_nettype wire

// ===== design/ipd_decode.sv =====
// Frame decoder: turns the captured body bytes of a finished frame into
// one result record. Purely combinational; depends on ipd_pkg.
`default_nettype none

module ipd_decode (
  input  wire ipd_pkg::cap_view_t view,
  input  wire logic [7:0]         last_byte,
  output ipd_pkg::result_t        result
);
  import ipd_pkg::*;

  logic [15:0] w4, w6, w8, w10, w12, w14;

  // Big-endian words at fixed body offsets; payload offset k is body offset 4 + k.
  assign w4  = {view[4],  view[5]};
  assign w6  = {view[6],  view[7]};
  assign w8  = {view[8],  view[9]};
  assign w10 = {view[10], view[11]};
  assign w12 = {view[12], view[13]};
  assign w14 = {view[14], view[15]};

  always_comb begin
    result                = '0;
    result.packet_type    = {view[0], view[1]};
    result.payload_length = {view[2], view[3]};
    result.checksum       = last_byte;
    priority if (result.packet_type == TYPE_ANGLE_Q87) begin
      result.kind  = KIND_ANGLE_Q87;
      result.roll  = {{16{w4[15]}}, w4};
      result.pitch = {{16{w6[15]}}, w6};
      result.yaw   = {{16{w8[15]}}, w8};
    end else if (result.packet_type == TYPE_ANGLE_FLOAT) begin
      result.kind  = KIND_ANGLE_FLOAT;
      result.roll  = {w4, w6};
      result.pitch = {w8, w10};
      result.yaw   = {w12, w14};
    end else if (result.packet_type == TYPE_TEST_INT) begin
      result.kind       = KIND_TEST_INT;
      result.test_value = {16'h0000, w4};
    end else if (result.packet_type == TYPE_TEST_FLOAT) begin
      result.kind       = KIND_TEST_FLOAT;
      result.test_value = {w4, w6};
    end else begin
      result.kind       = KIND_UNKNOWN;
      result.test_value = TEST_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

// ===== design/imu_packet_deframer_unit.sv =====
// Top level of the IMU packet deframer: length/body sequencing, capture
// store and the result register. Depends on ipd_pkg and ipd_decode.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | in_rx_byte
//   out_    | output    | out_valid/out_ready | out_frame_kind .. out_frame_checksum
//
// One byte is taken per cycle. A frame's result appears in the result register in the
// cycle after its last body byte is taken, decoded while that byte is taken from
// the capture store merged with the incoming byte.
// Input stalls only when the byte that completes a frame arrives while the
// result register still holds a result not yet taken; all other bytes pass.
// Synchronous active-low reset returns to awaiting a length high byte and
// clears the counters, the capture store and the result valid flag.
`default_nettype none

module imu_packet_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_frame_kind,
  output logic [15:0]      out_packet_type,
  output logic [15:0]      out_payload_length,
  output logic [31:0]      out_roll_bits,
  output logic [31:0]      out_pitch_bits,
  output logic [31:0]      out_yaw_bits,
  output logic [31:0]      out_test_value,
  output logic [7:0]       out_frame_checksum
);
  import ipd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] body_length_r, body_length_nxt;
  logic [15:0] body_count_r, body_count_nxt;
  cap_view_t   capture_r, capture_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, out_nxt;

  logic        in_take;
  logic        completes;
  logic [15:0] count_inc;
  logic [15:0] new_length;
  cap_view_t   view;
  result_t     decoded;

  assign count_inc  = body_count_r + 16'd1;
  assign new_length = {length_high_r, in_rx_byte};
  // Completion depends on state alone, so ready never looks at the payload.
  assign completes  = (phase_r == PH_BODY) && (count_inc >= body_length_r);
  assign in_ready   = !completes || !out_valid_r || out_ready;
  assign in_take    = in_valid && in_ready;

  // The last body byte is part of the decoded view in the cycle it arrives.
  always_comb begin
    for (int i = 0; i < CAPTURE_BYTES; i++) begin
      view[i] = ((phase_r == PH_BODY) && (body_count_r == 16'(i))) ? in_rx_byte
                                                                   : capture_r[i];
    end
  end

  ipd_decode u_decode (
    .view      (view),
    .last_byte (in_rx_byte),
    .result    (decoded)
  );

  always_comb begin
    phase_nxt       = phase_r;
    length_high_nxt = length_high_r;
    body_length_nxt = body_length_r;
    body_count_nxt  = body_count_r;
    capture_nxt     = capture_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_nxt         = out_r;
    if (in_take) begin
      unique case (phase_r)
        PH_LEN_HI: begin
          length_high_nxt = in_rx_byte;
          phase_nxt       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (new_length == 16'd0) begin
            phase_nxt = PH_LEN_HI;
          end else begin
            body_length_nxt = new_length;
            body_count_nxt  = 16'd0;
            capture_nxt     = '0;
            phase_nxt       = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_count_r < CAP_LIMIT) begin
            capture_nxt[body_count_r[CAP_IDX_W-1:0]] = in_rx_byte;
          end
          body_count_nxt = count_inc;
          if (completes) begin
            phase_nxt     = PH_LEN_HI;
            out_valid_nxt = 1'b1;
            out_nxt       = decoded;
          end
        end
        default: begin
          phase_nxt = PH_LEN_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEN_HI;
      length_high_r <= 8'd0;
      body_length_r <= 16'd0;
      body_count_r  <= 16'd0;
      capture_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      length_high_r <= length_high_nxt;
      body_length_r <= body_length_nxt;
      body_count_r  <= body_count_nxt;
      capture_r     <= capture_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_kind     = out_r.kind;
  assign out_packet_type    = out_r.packet_type;
  assign out_payload_length = out_r.payload_length;
  assign out_roll_bits      = out_r.roll;
  assign out_pitch_bits     = out_r.pitch;
  assign out_yaw_bits       = out_r.yaw;
  assign out_test_value     = out_r.test_value;
  assign out_frame_checksum = out_r.checksum;

  // A nonzero length starts a body with an empty capture store.
  a_capture_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && in_take && (phase_r == PH_LEN_LO) && (new_length != 16'd0))
    |=> (capture_r == '0) && (body_count_r == 16'd0))
    else $error("capture store not cleared at body start");

  // Inside a body the count stays below the declared length.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_count_r < body_length_r))
    else $error("body count reached body length inside a body");

  // A transaction that finishes no frame leaves no result behind.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !(in_take && completes) && (!out_valid_r || out_ready))
    |=> !out_valid_r)
    else $error("result valid without a completed frame");

  // A completing byte always loads the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && in_take && completes) |=> out_valid_r && (phase_r == PH_LEN_HI))
    else $error("completed frame did not produce a result");

endmodule

`default_nettype wire
